// ===== src/svsm_pkg.sv =====
// Types and constants shared by the voice mixer core.
// No dependencies.
`timescale 1ns / 1ps
package svsm_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SCHEDULE = 2'd1,
        OP_WRITE    = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_MIX      = 2'd0,
        KIND_CALLBACK = 2'd1,
        KIND_ANSWER   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_FREE   = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_ACTIVE = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACT,
        ST_FREE,
        ST_CB,
        ST_CB_OUT,
        ST_MIX_ADDR,
        ST_MIX_MUL,
        ST_MIX_ACC,
        ST_MIX_OUT,
        ST_ADV,
        ST_ANS,
        ST_WAIT_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [23:0]        delay_ticks;
        logic [23:0]        cb_delay;
        logic               has_callback;
        logic [15:0]        start_addr;
        logic [15:0]        frames;
        logic [3:0]         src_channels;
        logic [15:0]        tag;
        logic signed [15:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         channel;
        logic signed [19:0] mix_sample;
        logic [4:0]         voice;
        logic [15:0]        tag_out;
        logic               last;
    } out_item_t;

endpackage

// ===== src/svsm_sample_mem.sv =====
// Sample memory: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module svsm_sample_mem #(
    parameter int SAMPLE_WORDS = 65536,
    parameter int AW = $clog2(SAMPLE_WORDS)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [15:0]   wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic signed [15:0]   rd_data
);

    logic signed [15:0] mem [SAMPLE_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/sample_voice_scheduler_mixer_core.sv =====
// Top level of the voice mixer: voice table, sequencer and output register.
// Depends on svsm_pkg and svsm_sample_mem.
// Write stores one sample. Schedule scans slots up to the first free one, then answers.
// Tick: scans to activate, free and send callbacks, then one mix pass over all voices per output
// channel, then a pass to advance positions; one item at a time.
// Reset frees all voices, clears the tick count, sets output_channels to 2; memory not cleared.
`timescale 1ns / 1ps
module sample_voice_scheduler_mixer_core
    import svsm_pkg::*;
#(
    parameter int MAX_VOICES       = 16,
    parameter int MAX_OUT_CHANNELS = 8,
    parameter int SAMPLE_WORDS     = 65536
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [3:0] cfg_data
);

    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int AW = $clog2(SAMPLE_WORDS);
    localparam int SW = AW + 4;

    state_t state_reg, state_next;
    mode_t  mode_reg [MAX_VOICES];
    logic   cbp_reg  [MAX_VOICES];
    logic [31:0] onset_reg [MAX_VOICES];
    logic [31:0] cbon_reg  [MAX_VOICES];
    logic [15:0] pos_reg   [MAX_VOICES];
    logic [15:0] addr_reg  [MAX_VOICES];
    logic [15:0] frm_reg   [MAX_VOICES];
    logic [3:0]  src_reg   [MAX_VOICES];
    logic [15:0] tag_reg   [MAX_VOICES];

    logic [31:0] tick_reg;
    logic [3:0]  ocfg_reg;
    in_item_t    item_reg;
    logic [VW-1:0] v_reg;
    logic [CW-1:0] c_reg;
    logic        found_reg;
    logic [VW-1:0] slot_reg;
    logic signed [19:0] sum_reg;
    logic [31:0] prod_reg;
    logic        act_reg;
    logic        ovalid_reg;
    out_item_t   odata_reg;

    logic v_last, c_last;
    logic [VW-1:0] v_inc;
    logic [CW:0] nch;
    logic [3:0]  srcv;
    logic [3:0]  cmod;
    logic [15:0] lenm1;
    logic signed [15:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic out_load;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    always_comb
    begin
        if (ocfg_reg == 4'd0)
            nch = (CW+1)'(1);
        else if (32'(ocfg_reg) > MAX_OUT_CHANNELS)
            nch = (CW+1)'(MAX_OUT_CHANNELS);
        else
            nch = (CW+1)'(ocfg_reg);
    end

    assign v_last = (32'(v_reg) == MAX_VOICES - 1);
    assign v_inc  = v_last ? '0 : v_reg + VW'(1);
    assign c_last = (32'(c_reg) + 1 >= 32'(nch));
    assign srcv   = (src_reg[v_reg] == 4'd0) ? 4'd1 : src_reg[v_reg];
    assign lenm1  = (frm_reg[v_reg] == 16'd0) ? 16'd0 : frm_reg[v_reg] - 16'd1;

    // c mod src by shift and subtract, one step per channel-index bit
    always_comb
    begin
        logic [4:0] t;
        t = '0;
        for (int i = CW - 1; i >= 0; i--)
        begin
            t = {t[3:0], c_reg[i]};
            if (t >= 5'(srcv))
                t = t - 5'(srcv);
        end
        cmod = t[3:0];
    end

    assign rd_addr = AW'(SW'(prod_reg) + SW'(addr_reg[v_reg]) + SW'(cmod));
    assign wr_en   = (state_reg == ST_IDLE) && in_valid && in_ready
                     && (in_data.operation == OP_WRITE);
    assign out_load = (!ovalid_reg || out_ready)
                      && ((state_reg == ST_CB_OUT) || (state_reg == ST_MIX_OUT)
                          || (state_reg == ST_WAIT_OUT && item_reg.operation == OP_SCHEDULE));

    svsm_sample_mem #(.SAMPLE_WORDS(SAMPLE_WORDS), .AW(AW)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_data.start_addr)),
        .wr_data (in_data.sample_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_data.operation)
                        OP_TICK:     state_next = ST_ACT;
                        OP_SCHEDULE: state_next = ST_ANS;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACT:      state_next = v_last ? ST_FREE : ST_ACT;
            ST_FREE:     state_next = v_last ? ST_CB : ST_FREE;
            ST_CB:
            begin
                if (mode_reg[v_reg] == MODE_ACTIVE && cbp_reg[v_reg]
                    && tick_reg >= cbon_reg[v_reg])
                    state_next = ST_CB_OUT;
                else if (v_last)
                    state_next = ST_MIX_ADDR;
            end
            ST_CB_OUT:
            begin
                if (!ovalid_reg || out_ready)
                    state_next = v_last ? ST_MIX_ADDR : ST_CB;
            end
            ST_MIX_ADDR: state_next = ST_MIX_MUL;
            ST_MIX_MUL:  state_next = ST_MIX_ACC;
            ST_MIX_ACC:  state_next = v_last ? ST_MIX_OUT : ST_MIX_ADDR;
            ST_MIX_OUT:
            begin
                if (!ovalid_reg || out_ready)
                    state_next = c_last ? ST_ADV : ST_MIX_ADDR;
            end
            ST_ADV:      state_next = v_last ? ST_WAIT_OUT : ST_ADV;
            ST_ANS:
            begin
                if (v_last || mode_reg[v_reg] == MODE_FREE)
                    state_next = ST_WAIT_OUT;
            end
            ST_WAIT_OUT:
            begin
                if (!ovalid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tick_reg   <= '0;
            ocfg_reg   <= 4'd2;
            v_reg      <= '0;
            c_reg      <= '0;
            ovalid_reg <= 1'b0;
            found_reg  <= 1'b0;
            for (int i = 0; i < MAX_VOICES; i++)
            begin
                mode_reg[i] <= MODE_FREE;
                cbp_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                ocfg_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    v_reg     <= '0;
                    c_reg     <= '0;
                    found_reg <= 1'b0;
                    sum_reg   <= '0;
                    if (in_valid && in_ready)
                        item_reg <= in_data;
                end
                ST_ACT:
                begin
                    if (mode_reg[v_reg] == MODE_WAIT && tick_reg >= onset_reg[v_reg])
                        mode_reg[v_reg] <= MODE_ACTIVE;
                    v_reg <= v_inc;
                end
                ST_FREE:
                begin
                    if (mode_reg[v_reg] == MODE_ACTIVE && pos_reg[v_reg] >= lenm1)
                    begin
                        mode_reg[v_reg] <= MODE_FREE;
                        cbp_reg[v_reg]  <= 1'b0;
                    end
                    v_reg <= v_inc;
                end
                ST_CB:
                begin
                    if (!(mode_reg[v_reg] == MODE_ACTIVE && cbp_reg[v_reg]
                          && tick_reg >= cbon_reg[v_reg]))
                        v_reg <= v_inc;
                end
                ST_CB_OUT:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        cbp_reg[v_reg]       <= 1'b0;
                        odata_reg.kind       <= KIND_CALLBACK;
                        odata_reg.channel    <= '0;
                        odata_reg.mix_sample <= '0;
                        odata_reg.voice      <= 5'(v_reg) + 5'd1;
                        odata_reg.tag_out    <= tag_reg[v_reg];
                        odata_reg.last       <= 1'b0;
                        v_reg                <= v_inc;
                    end
                end
                ST_MIX_ADDR:
                begin
                    // shared multiplier: pos * src
                    prod_reg <= 32'(pos_reg[v_reg]) * 32'(srcv);
                    act_reg  <= (mode_reg[v_reg] == MODE_ACTIVE);
                end
                ST_MIX_ACC:
                begin
                    if (act_reg)
                        sum_reg <= sum_reg + 20'(rd_data);
                    v_reg <= v_inc;
                end
                ST_MIX_OUT:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        odata_reg.kind       <= KIND_MIX;
                        odata_reg.channel    <= 3'(c_reg);
                        odata_reg.mix_sample <= sum_reg;
                        odata_reg.voice      <= '0;
                        odata_reg.tag_out    <= '0;
                        odata_reg.last       <= c_last;
                        sum_reg              <= '0;
                        c_reg                <= c_reg + CW'(1);
                    end
                end
                ST_ADV:
                begin
                    if (mode_reg[v_reg] == MODE_ACTIVE)
                        pos_reg[v_reg] <= pos_reg[v_reg] + 16'd1;
                    if (v_last)
                        tick_reg <= tick_reg + 32'd1;
                    v_reg <= v_inc;
                end
                ST_ANS:
                begin
                    if (mode_reg[v_reg] == MODE_FREE)
                    begin
                        mode_reg[v_reg]  <= MODE_WAIT;
                        onset_reg[v_reg] <= tick_reg + 32'(item_reg.delay_ticks);
                        cbon_reg[v_reg]  <= tick_reg + 32'(item_reg.delay_ticks)
                                            + 32'(item_reg.cb_delay);
                        cbp_reg[v_reg]   <= item_reg.has_callback;
                        pos_reg[v_reg]   <= '0;
                        addr_reg[v_reg]  <= item_reg.start_addr;
                        frm_reg[v_reg]   <= item_reg.frames;
                        src_reg[v_reg]   <= item_reg.src_channels;
                        tag_reg[v_reg]   <= item_reg.tag;
                        found_reg        <= 1'b1;
                        slot_reg         <= v_reg;
                    end
                    else
                        v_reg <= v_inc;
                end
                ST_WAIT_OUT:
                begin
                    if ((!ovalid_reg || out_ready) && item_reg.operation == OP_SCHEDULE)
                    begin
                        odata_reg.kind       <= KIND_ANSWER;
                        odata_reg.channel    <= '0;
                        odata_reg.mix_sample <= '0;
                        odata_reg.voice      <= found_reg ? 5'(slot_reg) + 5'd1 : 5'd0;
                        odata_reg.tag_out    <= '0;
                        odata_reg.last       <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== src/svsm_checker.sv =====
// Port-level checks for the voice mixer core, bound to the top level.
// Depends on svsm_pkg and sample_voice_scheduler_mixer_core.
`timescale 1ns / 1ps
module svsm_checker
    import svsm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data,
    input logic      cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat dropped or changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready || out_data.last)
        else $error("input taken while a non-final beat is pending");

    a_answer_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_ANSWER |-> out_data.last)
        else $error("schedule answer without last");

    a_cb_voice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_CALLBACK |-> out_data.voice != 5'd0
        && !out_data.last)
        else $error("bad callback beat");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> cfg_ready)
        else $error("input ready while config blocked");

endmodule

bind sample_voice_scheduler_mixer_core svsm_checker u_svsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
